@@ rtl/ata_seq_pkg.sv @@
package ata_seq_pkg;

	// results per input item, and the width of a result count or index
	localparam int MAX_RES = 12;
	localparam int CNT_W   = 4;

	// configuration register indexes
	localparam logic [1:0] CFG_CAPACITY = 2'd0;
	localparam logic [1:0] CFG_WORDS    = 2'd1;
	localparam logic [1:0] CFG_SLAVE    = 2'd2;

	// input operations
	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_STATUS = 2'd1,
		OP_ERROR  = 2'd2,
		OP_DATA   = 2'd3
	} op_t;

	// result actions
	typedef enum logic [2:0] {
		ACT_WR   = 3'd0,
		ACT_RD   = 3'd1,
		ACT_HOST = 3'd2,
		ACT_PORT = 3'd3,
		ACT_DONE = 3'd4,
		ACT_ERR  = 3'd5
	} action_t;

	// sequencer phase, one-hot
	typedef enum logic [5:0] {
		PH_IDLE     = 6'b000001,
		PH_POLL_BSY = 6'b000010,
		PH_POLL_DRQ = 6'b000100,
		PH_ERR_WAIT = 6'b001000,
		PH_DATA     = 6'b010000,
		PH_FINAL    = 6'b100000
	} phase_t;

	// task file offsets
	localparam logic [4:0] P_NONE   = 5'd0;
	localparam logic [4:0] P_DATA   = 5'd0;
	localparam logic [4:0] P_ERROR  = 5'd0;
	localparam logic [4:0] P_COUNT  = 5'd2;
	localparam logic [4:0] P_LBA0   = 5'd3;
	localparam logic [4:0] P_LBA1   = 5'd4;
	localparam logic [4:0] P_LBA2   = 5'd5;
	localparam logic [4:0] P_SELECT = 5'd6;
	localparam logic [4:0] P_CMD    = 5'd7;
	localparam logic [4:0] P_STATUS = 5'd7;
	localparam logic [4:0] P_ALT    = 5'd16;

	// status register bits
	localparam int ST_ERR = 0;
	localparam int ST_DF  = 1;
	localparam int ST_DRQ = 3;
	localparam int ST_BSY = 7;

	// command bytes
	localparam logic [7:0] SELECT_BASE = 8'hE0;
	localparam logic [7:0] CMD_READ    = 8'h20;
	localparam logic [7:0] CMD_WRITE   = 8'h30;
	localparam logic [7:0] CMD_FLUSH   = 8'hE7;

	// error codes
	localparam logic [3:0] ERR_NONE   = 4'd0;
	localparam logic [3:0] ERR_BOUNDS = 4'd1;
	localparam logic [3:0] ERR_LBA48  = 4'd2;
	localparam logic [3:0] ERR_FAULT  = 4'd3;
	localparam logic [3:0] ERR_BIT0   = 4'd4;
	localparam logic [3:0] ERR_NO_BIT = 4'd12;

	typedef struct packed {
		action_t     action;
		logic [4:0]  port;
		logic [15:0] value;
		logic [3:0]  error_code;
	} res_t;

	typedef struct packed {
		phase_t      phase;
		logic        dir;
		logic [7:0]  sectors;
		logic [15:0] words;
	} state_t;

	typedef struct packed {
		op_t         op;
		logic        wdir;
		logic [27:0] lba;
		logic [7:0]  count;
		logic [7:0]  reg_value;
		logic [15:0] word;
		logic        bounds_err;
		logic        lba48_err;
	} item_t;

	function automatic res_t mk_res(action_t act, logic [4:0] p, logic [15:0] v,
		logic [3:0] code);
		res_t r;
		r.action     = act;
		r.port       = p;
		r.value      = v;
		r.error_code = code;
		return r;
	endfunction

endpackage

@@ rtl/ata_pio_lba28_command_sequencer.sv @@
// Host-side ATA PIO LBA28 command sequencer.
// Input channel (in_valid/in_stall) takes one beat per operation: a start
// command, a status byte, an error byte or a data word. Output channel
// (out_valid/out_stall) gives one result per beat: task-file writes and
// reads, data words to host or port, done and error, with last marking the
// final result of each input beat. Inputs that the current phase does not
// expect cause no result.
// An accepted beat is held in the input register; when the burst buffer is free
// its results are loaded there, and the first is presented from the buffer.
// Throughput: one input beat per cycle while each makes at most one result and
// out_stall stays low; a beat that makes n results (up to 11) gives them one per
// output beat, and the input register takes the next beat meanwhile, then stalls.
// The range check (48-bit lba plus count against capacity) is done as the
// beat enters the input register.
// Reset clears the phase to idle, the counters, and the configuration to
// capacity 0, 256 words per sector and master drive. Configuration writes
// (cfg_wen, cfg_index, cfg_data) belong to idle periods only.
// When out_stall is high the current result holds and in_stall rises as soon
// as the input register is occupied.
module ata_pio_lba28_command_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic        write_dir,
	input  logic [47:0] lba,
	input  logic [7:0]  num_sectors,
	input  logic [7:0]  reg_value,
	input  logic [15:0] data_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [4:0]  port,
	output logic [15:0] value,
	output logic [3:0]  error_code,
	output logic        last
);

	logic [47:0]         capacity_q;
	logic [15:0]         words_q;
	logic                slave_q;
	ata_seq_pkg::item_t  item_s1;
	logic                valid_s1;
	ata_seq_pkg::state_t state_q;
	ata_seq_pkg::state_t state_d;
	ata_seq_pkg::res_t   dec_res [ata_seq_pkg::MAX_RES];
	logic [ata_seq_pkg::CNT_W-1:0] dec_count;
	ata_seq_pkg::res_t   out_res;
	logic                burst_free;
	logic                accept;
	logic                advance;
	logic                bounds_err;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
			words_q    <= 16'd256;
			slave_q    <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				ata_seq_pkg::CFG_CAPACITY: capacity_q <= cfg_data;
				ata_seq_pkg::CFG_WORDS:    words_q    <= cfg_data[15:0];
				ata_seq_pkg::CFG_SLAVE:    slave_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input handshake
	assign advance  = valid_s1 && burst_free;
	assign in_stall = valid_s1 && !burst_free;
	assign accept   = in_valid && !in_stall;

	// range check on the incoming beat
	assign bounds_err = ({1'b0, lba} + {41'd0, num_sectors}) > {1'b0, capacity_q};

	// input register
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op         <= ata_seq_pkg::op_t'(operation);
			item_s1.wdir       <= write_dir;
			item_s1.lba        <= lba[27:0];
			item_s1.count      <= num_sectors;
			item_s1.reg_value  <= reg_value;
			item_s1.word       <= data_word;
			item_s1.bounds_err <= bounds_err;
			item_s1.lba48_err  <= |lba[47:28];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase   <= ata_seq_pkg::PH_IDLE;
			state_q.dir     <= 1'b0;
			state_q.sectors <= '0;
			state_q.words   <= '0;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	ata_seq_decode u_decode (
		.item             (item_s1),
		.cur              (state_q),
		.words_per_sector (words_q),
		.drive_slave      (slave_q),
		.nxt              (state_d),
		.res              (dec_res),
		.count            (dec_count)
	);

	ata_seq_burst u_burst (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance && dec_count != '0),
		.load_res   (dec_res),
		.load_count (dec_count),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_res    (out_res),
		.out_last   (last),
		.free       (burst_free)
	);

	assign action     = out_res.action;
	assign port       = out_res.port;
	assign value      = out_res.value;
	assign error_code = out_res.error_code;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid)
		else $error("input stalled with nothing pending");

endmodule

@@ rtl/ata_seq_decode.sv @@
module ata_seq_decode (
	input  ata_seq_pkg::item_t  item,
	input  ata_seq_pkg::state_t cur,
	input  logic [15:0]         words_per_sector,
	input  logic                drive_slave,
	output ata_seq_pkg::state_t nxt,
	output ata_seq_pkg::res_t   res [ata_seq_pkg::MAX_RES],
	output logic [ata_seq_pkg::CNT_W-1:0] count
);

	logic [ata_seq_pkg::CNT_W-1:0] n;
	logic                          drq;
	logic                          start_data;
	logic                          after;
	logic [3:0]                    code;
	logic [7:0]                    sel;

	// build the result list and next state for one item
	always_comb begin
		n          = '0;
		drq        = 1'b0;
		start_data = 1'b0;
		after      = 1'b0;
		code       = ata_seq_pkg::ERR_NO_BIT;
		sel        = ata_seq_pkg::SELECT_BASE | {3'b000, drive_slave, item.lba[27:24]};
		nxt        = cur;
		for (int i = 0; i < ata_seq_pkg::MAX_RES; i++) begin
			res[i] = '0;
		end

		unique case (item.op)
			ata_seq_pkg::OP_START: begin
				if (cur.phase == ata_seq_pkg::PH_IDLE) begin
					if (item.bounds_err) begin
						res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_ERR, ata_seq_pkg::P_NONE,
							16'd0, ata_seq_pkg::ERR_BOUNDS);
						n = n + 1'b1;
					end else if (item.lba48_err) begin
						res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_ERR, ata_seq_pkg::P_NONE,
							16'd0, ata_seq_pkg::ERR_LBA48);
						n = n + 1'b1;
					end else begin
						nxt.dir     = item.wdir;
						nxt.sectors = item.count;
						res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_WR, ata_seq_pkg::P_SELECT,
							{8'd0, sel}, ata_seq_pkg::ERR_NONE);
						n = n + 1'b1;
						res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_WR, ata_seq_pkg::P_COUNT,
							{8'd0, item.count}, ata_seq_pkg::ERR_NONE);
						n = n + 1'b1;
						res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_WR, ata_seq_pkg::P_LBA0,
							{8'd0, item.lba[7:0]}, ata_seq_pkg::ERR_NONE);
						n = n + 1'b1;
						res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_WR, ata_seq_pkg::P_LBA1,
							{8'd0, item.lba[15:8]}, ata_seq_pkg::ERR_NONE);
						n = n + 1'b1;
						res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_WR, ata_seq_pkg::P_LBA2,
							{8'd0, item.lba[23:16]}, ata_seq_pkg::ERR_NONE);
						n = n + 1'b1;
						res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_WR, ata_seq_pkg::P_CMD,
							{8'd0, item.wdir ? ata_seq_pkg::CMD_WRITE : ata_seq_pkg::CMD_READ},
							ata_seq_pkg::ERR_NONE);
						n = n + 1'b1;
						after = 1'b1;
					end
				end
			end
			ata_seq_pkg::OP_STATUS: begin
				if (cur.phase == ata_seq_pkg::PH_POLL_BSY) begin
					if (item.reg_value[ata_seq_pkg::ST_BSY]) begin
						res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_RD, ata_seq_pkg::P_STATUS,
							16'd0, ata_seq_pkg::ERR_NONE);
						n = n + 1'b1;
					end else if (cur.dir) begin
						start_data = 1'b1;
					end else begin
						drq = 1'b1;
					end
				end else if (cur.phase == ata_seq_pkg::PH_POLL_DRQ) begin
					drq = 1'b1;
				end else if (cur.phase == ata_seq_pkg::PH_FINAL) begin
					if (item.reg_value[ata_seq_pkg::ST_BSY]) begin
						res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_RD, ata_seq_pkg::P_STATUS,
							16'd0, ata_seq_pkg::ERR_NONE);
						n = n + 1'b1;
					end else begin
						res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_WR, ata_seq_pkg::P_CMD,
							{8'd0, ata_seq_pkg::CMD_FLUSH}, ata_seq_pkg::ERR_NONE);
						n = n + 1'b1;
						res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_DONE, ata_seq_pkg::P_NONE,
							16'd0, ata_seq_pkg::ERR_NONE);
						n = n + 1'b1;
						nxt.phase = ata_seq_pkg::PH_IDLE;
					end
				end
			end
			ata_seq_pkg::OP_ERROR: begin
				if (cur.phase == ata_seq_pkg::PH_ERR_WAIT) begin
					// lowest set error bit wins
					for (int b = 7; b >= 0; b--) begin
						if (item.reg_value[b]) begin
							code = ata_seq_pkg::ERR_BIT0 + 4'(b);
						end
					end
					res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_ERR, ata_seq_pkg::P_NONE,
						16'd0, code);
					n = n + 1'b1;
					nxt.phase = ata_seq_pkg::PH_IDLE;
				end
			end
			ata_seq_pkg::OP_DATA: begin
				if (cur.phase == ata_seq_pkg::PH_DATA) begin
					if (cur.dir) begin
						res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_PORT, ata_seq_pkg::P_DATA,
							item.word, ata_seq_pkg::ERR_NONE);
					end else begin
						res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_HOST, ata_seq_pkg::P_NONE,
							item.word, ata_seq_pkg::ERR_NONE);
					end
					n = n + 1'b1;
					nxt.words = cur.words - 16'd1;
					if (nxt.words != 16'd0) begin
						if (!cur.dir) begin
							res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_RD, ata_seq_pkg::P_DATA,
								16'd0, ata_seq_pkg::ERR_NONE);
							n = n + 1'b1;
						end
					end else begin
						nxt.sectors = cur.sectors - 8'd1;
						after = 1'b1;
					end
				end
			end
		endcase

		// read status check: data request, error, fault or keep polling
		if (drq) begin
			if (item.reg_value[ata_seq_pkg::ST_DRQ]) begin
				start_data = 1'b1;
			end else if (item.reg_value[ata_seq_pkg::ST_ERR]) begin
				res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_RD, ata_seq_pkg::P_ERROR,
					16'd0, ata_seq_pkg::ERR_NONE);
				n = n + 1'b1;
				nxt.phase = ata_seq_pkg::PH_ERR_WAIT;
			end else if (item.reg_value[ata_seq_pkg::ST_DF]) begin
				res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_ERR, ata_seq_pkg::P_NONE,
					16'd0, ata_seq_pkg::ERR_FAULT);
				n = n + 1'b1;
				nxt.phase = ata_seq_pkg::PH_IDLE;
			end else begin
				res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_RD, ata_seq_pkg::P_STATUS,
					16'd0, ata_seq_pkg::ERR_NONE);
				n = n + 1'b1;
				nxt.phase = ata_seq_pkg::PH_POLL_DRQ;
			end
		end

		// sector data start, an empty sector counts as done
		if (start_data) begin
			nxt.words = words_per_sector;
			if (words_per_sector == 16'd0) begin
				nxt.sectors = nxt.sectors - 8'd1;
				after = 1'b1;
			end else begin
				nxt.phase = ata_seq_pkg::PH_DATA;
				if (!nxt.dir) begin
					res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_RD, ata_seq_pkg::P_DATA,
						16'd0, ata_seq_pkg::ERR_NONE);
					n = n + 1'b1;
				end
			end
		end

		// next sector, final busy wait, or done
		if (after) begin
			if (nxt.sectors != 8'd0 || nxt.dir) begin
				for (int k = 0; k < 4; k++) begin
					res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_RD, ata_seq_pkg::P_ALT,
						16'd0, ata_seq_pkg::ERR_NONE);
					n = n + 1'b1;
				end
				res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_RD, ata_seq_pkg::P_STATUS,
					16'd0, ata_seq_pkg::ERR_NONE);
				n = n + 1'b1;
				nxt.phase = (nxt.sectors != 8'd0) ? ata_seq_pkg::PH_POLL_BSY
					: ata_seq_pkg::PH_FINAL;
			end else begin
				res[n] = ata_seq_pkg::mk_res(ata_seq_pkg::ACT_DONE, ata_seq_pkg::P_NONE,
					16'd0, ata_seq_pkg::ERR_NONE);
				n = n + 1'b1;
				nxt.phase = ata_seq_pkg::PH_IDLE;
			end
		end

		count = n;
	end

endmodule

@@ rtl/ata_seq_burst.sv @@
module ata_seq_burst (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  ata_seq_pkg::res_t             load_res [ata_seq_pkg::MAX_RES],
	input  logic [ata_seq_pkg::CNT_W-1:0] load_count,
	input  logic                          out_stall,
	output logic                          out_valid,
	output ata_seq_pkg::res_t             out_res,
	output logic                          out_last,
	output logic                          free
);

	ata_seq_pkg::res_t             buf_q [ata_seq_pkg::MAX_RES];
	logic [ata_seq_pkg::CNT_W-1:0] count_q;
	logic [ata_seq_pkg::CNT_W-1:0] idx_q;
	logic                          valid_q;
	logic                          take;

	// one result leaves per beat
	assign take      = valid_q && !out_stall;
	assign out_valid = valid_q;
	assign out_res   = buf_q[idx_q];
	assign out_last  = (idx_q == count_q - 1'b1);
	assign free      = !valid_q || (take && out_last);

	// result list storage
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < ata_seq_pkg::MAX_RES; i++) begin
				buf_q[i] <= load_res[i];
			end
		end
	end

	// burst position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			count_q <= '0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			count_q <= load_count;
			idx_q   <= '0;
		end else if (take) begin
			if (out_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> count_q != '0)
		else $error("burst holds an empty result list");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> idx_q < count_q)
		else $error("burst index past result count");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("burst loaded over pending results");

endmodule

@@ sim/ata_pio_lba28_command_sequencer_test.sv @@
module ata_pio_lba28_command_sequencer_test;

	localparam int          CYCLE_LIMIT = 2000000;
	localparam logic [1:0]  CFG_SPARE   = 2'd3;
	localparam logic [47:0] MAX48       = 48'hFFFF_FFFF_FFFF;
	localparam logic [63:0] LBA28_TOP   = 64'h0FFF_FFFF;

	// one input beat as the sequencer sees it
	typedef struct {
		ata_seq_pkg::op_t op;
		logic        wdir;
		logic [47:0] lba;
		logic [7:0]  cnt;
		logic [7:0]  regv;
		logic [15:0] word;
	} pio_in_t;

	// one bus operation the sequencer should emit
	typedef struct packed {
		ata_seq_pkg::action_t action;
		logic [4:0]  port;
		logic [15:0] value;
		logic [3:0]  code;
		logic        last;
	} host_op_t;

	// directed stimulus row: a register write or an input beat
	typedef struct {
		logic        is_cfg;
		logic [1:0]  cfg_idx;
		logic [47:0] cfg_val;
		pio_in_t     item;
		logic        typed;
		logic [3:0]  code;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [47:0] cfg_data = 48'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = 2'd0;
	logic        write_dir = 1'b0;
	logic [47:0] lba = 48'd0;
	logic [7:0]  num_sectors = 8'd0;
	logic [7:0]  reg_value = 8'd0;
	logic [15:0] data_word = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  action;
	logic [4:0]  port;
	logic [15:0] value;
	logic [3:0]  error_code;
	logic        last;

	// sequencer state and registers as predicted
	ata_seq_pkg::phase_t seq_phase = ata_seq_pkg::PH_IDLE;
	logic        seq_dir = 1'b0;
	logic [7:0]  secs_left = 8'd0;
	logic [15:0] words_left = 16'd0;
	logic [47:0] cap_sectors = 48'd0;
	logic [15:0] words_per_sec = 16'd256;
	logic        slave_sel = 1'b0;

	host_op_t    step_ops[$];
	host_op_t    ops_due[$];
	plan_row_t   plan[$];

	int          fail_count = 0;
	int          cycle_count = 0;
	int          items_sent = 0;
	int          items_taken = 0;
	int          beats_seen = 0;
	bit          steady = 1'b0;
	bit          holding = 1'b0;
	bit          hold_go = 1'b0;

	ata_pio_lba28_command_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .write_dir(write_dir), .lba(lba),
		.num_sectors(num_sectors), .reg_value(reg_value), .data_word(data_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.action(action), .port(port), .value(value),
		.error_code(error_code), .last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		fail_count++;
	endtask

	// prediction
	function automatic void queue_op(ata_seq_pkg::action_t act, logic [4:0] p,
		logic [15:0] v, logic [3:0] code);
		host_op_t o;
		o.action = act;
		o.port   = p;
		o.value  = v;
		o.code   = code;
		o.last   = 1'b0;
		step_ops.insert(step_ops.size(), o);
	endfunction

	// four alt-status reads to let the drive settle, then a status read
	function automatic void poll_status();
		repeat (4)
			queue_op(ata_seq_pkg::ACT_RD, ata_seq_pkg::P_ALT, 16'd0, ata_seq_pkg::ERR_NONE);
		queue_op(ata_seq_pkg::ACT_RD, ata_seq_pkg::P_STATUS, 16'd0, ata_seq_pkg::ERR_NONE);
	endfunction

	function automatic void next_sector();
		if (secs_left != 8'd0) begin
			seq_phase = ata_seq_pkg::PH_POLL_BSY;
			poll_status();
		end else if (seq_dir) begin
			seq_phase = ata_seq_pkg::PH_FINAL;
			poll_status();
		end else begin
			seq_phase = ata_seq_pkg::PH_IDLE;
			queue_op(ata_seq_pkg::ACT_DONE, ata_seq_pkg::P_NONE, 16'd0, ata_seq_pkg::ERR_NONE);
		end
	endfunction

	function automatic void open_sector();
		words_left = words_per_sec;
		if (words_left == 16'd0) begin
			secs_left = secs_left - 8'd1;
			next_sector();
		end else begin
			seq_phase = ata_seq_pkg::PH_DATA;
			if (!seq_dir)
				queue_op(ata_seq_pkg::ACT_RD, ata_seq_pkg::P_DATA, 16'd0,
					ata_seq_pkg::ERR_NONE);
		end
	endfunction

	function automatic void check_drq(logic [7:0] st);
		if (st[ata_seq_pkg::ST_DRQ])
			open_sector();
		else if (st[ata_seq_pkg::ST_ERR]) begin
			seq_phase = ata_seq_pkg::PH_ERR_WAIT;
			queue_op(ata_seq_pkg::ACT_RD, ata_seq_pkg::P_ERROR, 16'd0, ata_seq_pkg::ERR_NONE);
		end else if (st[ata_seq_pkg::ST_DF]) begin
			seq_phase = ata_seq_pkg::PH_IDLE;
			queue_op(ata_seq_pkg::ACT_ERR, ata_seq_pkg::P_NONE, 16'd0, ata_seq_pkg::ERR_FAULT);
		end else begin
			seq_phase = ata_seq_pkg::PH_POLL_DRQ;
			queue_op(ata_seq_pkg::ACT_RD, ata_seq_pkg::P_STATUS, 16'd0, ata_seq_pkg::ERR_NONE);
		end
	endfunction

	// one accepted beat: fills step_ops, returns 0 if the beat is ignored
	function automatic bit sequencer_step(pio_in_t it);
		bit taken;
		logic [3:0] code;
		step_ops.delete();
		taken = 1'b1;
		if (it.op == ata_seq_pkg::OP_START && seq_phase == ata_seq_pkg::PH_IDLE) begin
			if ({1'b0, it.lba} + it.cnt > {1'b0, cap_sectors})
				queue_op(ata_seq_pkg::ACT_ERR, ata_seq_pkg::P_NONE, 16'd0,
					ata_seq_pkg::ERR_BOUNDS);
			else if (it.lba[47:28] != 20'd0)
				queue_op(ata_seq_pkg::ACT_ERR, ata_seq_pkg::P_NONE, 16'd0,
					ata_seq_pkg::ERR_LBA48);
			else begin
				seq_dir   = it.wdir;
				secs_left = it.cnt;
				queue_op(ata_seq_pkg::ACT_WR, ata_seq_pkg::P_SELECT,
					{8'd0, ata_seq_pkg::SELECT_BASE | {3'b000, slave_sel, it.lba[27:24]}},
					ata_seq_pkg::ERR_NONE);
				queue_op(ata_seq_pkg::ACT_WR, ata_seq_pkg::P_COUNT, {8'd0, it.cnt},
					ata_seq_pkg::ERR_NONE);
				queue_op(ata_seq_pkg::ACT_WR, ata_seq_pkg::P_LBA0, {8'd0, it.lba[7:0]},
					ata_seq_pkg::ERR_NONE);
				queue_op(ata_seq_pkg::ACT_WR, ata_seq_pkg::P_LBA1, {8'd0, it.lba[15:8]},
					ata_seq_pkg::ERR_NONE);
				queue_op(ata_seq_pkg::ACT_WR, ata_seq_pkg::P_LBA2, {8'd0, it.lba[23:16]},
					ata_seq_pkg::ERR_NONE);
				queue_op(ata_seq_pkg::ACT_WR, ata_seq_pkg::P_CMD,
					{8'd0, it.wdir ? ata_seq_pkg::CMD_WRITE : ata_seq_pkg::CMD_READ},
					ata_seq_pkg::ERR_NONE);
				next_sector();
			end
		end else if (it.op == ata_seq_pkg::OP_STATUS
			&& seq_phase == ata_seq_pkg::PH_POLL_BSY) begin
			if (it.regv[ata_seq_pkg::ST_BSY])
				queue_op(ata_seq_pkg::ACT_RD, ata_seq_pkg::P_STATUS, 16'd0,
					ata_seq_pkg::ERR_NONE);
			else if (seq_dir)
				open_sector();
			else
				check_drq(it.regv);
		end else if (it.op == ata_seq_pkg::OP_STATUS
			&& seq_phase == ata_seq_pkg::PH_POLL_DRQ) begin
			check_drq(it.regv);
		end else if (it.op == ata_seq_pkg::OP_STATUS
			&& seq_phase == ata_seq_pkg::PH_FINAL) begin
			if (it.regv[ata_seq_pkg::ST_BSY])
				queue_op(ata_seq_pkg::ACT_RD, ata_seq_pkg::P_STATUS, 16'd0,
					ata_seq_pkg::ERR_NONE);
			else begin
				queue_op(ata_seq_pkg::ACT_WR, ata_seq_pkg::P_CMD,
					{8'd0, ata_seq_pkg::CMD_FLUSH}, ata_seq_pkg::ERR_NONE);
				queue_op(ata_seq_pkg::ACT_DONE, ata_seq_pkg::P_NONE, 16'd0,
					ata_seq_pkg::ERR_NONE);
				seq_phase = ata_seq_pkg::PH_IDLE;
			end
		end else if (it.op == ata_seq_pkg::OP_ERROR
			&& seq_phase == ata_seq_pkg::PH_ERR_WAIT) begin
			// lowest set error bit wins
			code = ata_seq_pkg::ERR_NO_BIT;
			for (int b = 7; b >= 0; b--)
				if (it.regv[b])
					code = ata_seq_pkg::ERR_BIT0 + 4'(b);
			queue_op(ata_seq_pkg::ACT_ERR, ata_seq_pkg::P_NONE, 16'd0, code);
			seq_phase = ata_seq_pkg::PH_IDLE;
		end else if (it.op == ata_seq_pkg::OP_DATA && seq_phase == ata_seq_pkg::PH_DATA) begin
			if (seq_dir)
				queue_op(ata_seq_pkg::ACT_PORT, ata_seq_pkg::P_DATA, it.word,
					ata_seq_pkg::ERR_NONE);
			else
				queue_op(ata_seq_pkg::ACT_HOST, ata_seq_pkg::P_NONE, it.word,
					ata_seq_pkg::ERR_NONE);
			words_left = words_left - 16'd1;
			if (words_left != 16'd0) begin
				if (!seq_dir)
					queue_op(ata_seq_pkg::ACT_RD, ata_seq_pkg::P_DATA, 16'd0,
						ata_seq_pkg::ERR_NONE);
			end else begin
				secs_left = secs_left - 8'd1;
				next_sector();
			end
		end else
			taken = 1'b0;
		if (step_ops.size() > 0)
			step_ops[step_ops.size() - 1].last = 1'b1;
		return taken;
	endfunction

	// stimulus generation; tidy picks only beats that move toward idle
	function automatic pio_in_t pick_item(input bit tidy);
		pio_in_t it;
		logic [63:0] room;
		int k;
		it.op   = ata_seq_pkg::op_t'($urandom_range(3));
		it.wdir = 1'($urandom_range(1));
		it.lba  = 48'({$urandom, $urandom});
		it.cnt  = 8'($urandom);
		it.regv = 8'($urandom);
		it.word = 16'($urandom);
		if (!tidy && $urandom_range(99) < 15)
			return it;
		case (seq_phase)
			ata_seq_pkg::PH_IDLE: begin
				it.op = ata_seq_pkg::OP_START;
				if ($urandom_range(99) >= 4)
					it.cnt = 8'($urandom_range(4));
				if ($urandom_range(99) < 80 && {16'd0, cap_sectors} >= it.cnt) begin
					room = {16'd0, cap_sectors} - it.cnt;
					if (room > LBA28_TOP)
						room = LBA28_TOP;
					if ($urandom_range(9) == 0)
						it.lba = room[47:0];
					else
						it.lba = 48'({$urandom, $urandom} % (room + 64'd1));
				end
			end
			ata_seq_pkg::PH_POLL_BSY, ata_seq_pkg::PH_POLL_DRQ, ata_seq_pkg::PH_FINAL: begin
				it.op = ata_seq_pkg::OP_STATUS;
				k = $urandom_range(9);
				if (!tidy && k < 2)
					it.regv[ata_seq_pkg::ST_BSY] = 1'b1;
				else begin
					it.regv[ata_seq_pkg::ST_BSY] = 1'b0;
					if (tidy || k < 7)
						it.regv[ata_seq_pkg::ST_DRQ] = 1'b1;
					else begin
						it.regv[ata_seq_pkg::ST_DRQ] = 1'b0;
						if (k == 7)
							it.regv[ata_seq_pkg::ST_ERR] = 1'b1;
						else begin
							it.regv[ata_seq_pkg::ST_ERR] = 1'b0;
							it.regv[ata_seq_pkg::ST_DF]  = (k == 8);
						end
					end
				end
			end
			ata_seq_pkg::PH_ERR_WAIT: begin
				it.op   = ata_seq_pkg::OP_ERROR;
				it.regv = 8'($urandom) << $urandom_range(7);
			end
			ata_seq_pkg::PH_DATA: it.op = ata_seq_pkg::OP_DATA;
			default: ;
		endcase
		return it;
	endfunction

	// present one beat, hold it until accepted, then predict its results
	task automatic offer(input pio_in_t it, input bit typed, input logic [3:0] code,
		output bit taken);
		host_op_t fixed;
		while (!steady && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= it.op;
		write_dir    <= it.wdir;
		lba          <= it.lba;
		num_sectors  <= it.cnt;
		reg_value    <= it.regv;
		data_word    <= it.word;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		taken = sequencer_step(it);
		if (taken)
			items_taken++;
		if (typed) begin
			fixed.action = ata_seq_pkg::ACT_ERR;
			fixed.port   = ata_seq_pkg::P_NONE;
			fixed.value  = 16'd0;
			fixed.code   = code;
			fixed.last   = 1'b1;
			ops_due.insert(ops_due.size(), fixed);
		end else
			foreach (step_ops[i])
				ops_due.insert(ops_due.size(), step_ops[i]);
	endtask

	// finish any open command, drain the results, and let the pipe empty
	task automatic settle();
		pio_in_t it;
		bit taken;
		int guard;
		while (seq_phase != ata_seq_pkg::PH_IDLE) begin
			it = pick_item(1'b1);
			offer(it, 1'b0, ata_seq_pkg::ERR_NONE, taken);
		end
		in_valid <= 1'b0;
		for (guard = 0; guard < 20000 && ops_due.size() != 0; guard++)
			@(posedge clk);
		if (ops_due.size() != 0) begin
			report($sformatf("%0d expected results never arrived", ops_due.size()));
			ops_due.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			ata_seq_pkg::CFG_CAPACITY: cap_sectors = val;
			ata_seq_pkg::CFG_WORDS:    words_per_sec = val[15:0];
			ata_seq_pkg::CFG_SLAVE:    slave_sel = val[0];
			default: ;
		endcase
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	// directed table builders
	function automatic pio_in_t pio(ata_seq_pkg::op_t op, logic w, logic [47:0] a,
		logic [7:0] c, logic [7:0] r, logic [15:0] d);
		pio_in_t it;
		it.op   = op;
		it.wdir = w;
		it.lba  = a;
		it.cnt  = c;
		it.regv = r;
		it.word = d;
		return it;
	endfunction

	function automatic void add_step(pio_in_t it);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.item   = it;
		row.typed  = 1'b0;
		row.code   = ata_seq_pkg::ERR_NONE;
		plan.insert(plan.size(), row);
	endfunction

	function automatic void add_fail(pio_in_t it, logic [3:0] code);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.item   = it;
		row.typed  = 1'b1;
		row.code   = code;
		plan.insert(plan.size(), row);
	endfunction

	function automatic void add_cfg(logic [1:0] idx, logic [47:0] v);
		plan_row_t row;
		row.is_cfg  = 1'b1;
		row.cfg_idx = idx;
		row.cfg_val = v;
		row.typed   = 1'b0;
		plan.insert(plan.size(), row);
	endfunction

	// result checker and receiver stall
	always @(posedge clk) begin : check_results
		host_op_t want;
		if (out_valid && !out_stall) begin
			beats_seen++;
			if (ops_due.size() == 0)
				report($sformatf("result act %0d port %0d value %h with nothing expected",
					action, port, value));
			else begin
				want = ops_due.pop_front();
				if (action !== want.action || port !== want.port || value !== want.value
					|| error_code !== want.code || last !== want.last)
					report({$sformatf("beat %0d: got act %0d port %0d val %h code %0d last %b, ",
						beats_seen, action, port, value, error_code, last),
						$sformatf("want act %0d port %0d val %h code %0d last %b",
						want.action, want.port, want.value, want.code, want.last)});
			end
		end
		out_stall <= holding || (!steady && $urandom_range(99) < 32);
	end

	// one long receiver hold-off so the input side backs up
	initial begin : receiver_hold
		int n;
		wait (hold_go);
		@(posedge clk);
		holding <= 1'b1;
		for (n = 0; n < 120; n++)
			@(posedge clk);
		holding <= 1'b0;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("ata_pio_lba28_command_sequencer_test NOT OK");
			$finish;
		end
	end

	initial begin : stimulus
		pio_in_t it;
		bit taken;
		int k;

		// reset state: zero capacity, 256 words, master drive
		add_step(pio(ata_seq_pkg::OP_START, 1'b0, 48'd0, 8'd0, 8'd0, 16'd0));
		add_fail(pio(ata_seq_pkg::OP_START, 1'b0, 48'd0, 8'd1, 8'd0, 16'd0),
			ata_seq_pkg::ERR_BOUNDS);
		add_cfg(ata_seq_pkg::CFG_CAPACITY, MAX48);
		add_cfg(ata_seq_pkg::CFG_WORDS, 48'd2);
		add_cfg(ata_seq_pkg::CFG_SLAVE, 48'd1);
		add_fail(pio(ata_seq_pkg::OP_START, 1'b0, MAX48, 8'd0, 8'd0, 16'd0),
			ata_seq_pkg::ERR_LBA48);
		add_fail(pio(ata_seq_pkg::OP_START, 1'b1, MAX48, 8'd255, 8'd0, 16'd0),
			ata_seq_pkg::ERR_BOUNDS);
		// zero-count write goes straight to the flush
		add_step(pio(ata_seq_pkg::OP_START, 1'b1, 48'h0FFF_FFFF, 8'd0, 8'd0, 16'd0));
		add_step(pio(ata_seq_pkg::OP_STATUS, 1'b0, 48'd0, 8'd0, 8'hFF, 16'd0));
		add_step(pio(ata_seq_pkg::OP_STATUS, 1'b0, 48'd0, 8'd0, 8'h7F, 16'd0));
		// one-sector read through busy, drq wait, and both data words
		add_step(pio(ata_seq_pkg::OP_START, 1'b0, 48'h0123456, 8'd1, 8'd0, 16'd0));
		add_step(pio(ata_seq_pkg::OP_START, 1'b1, 48'd0, 8'd5, 8'd0, 16'd0));
		add_step(pio(ata_seq_pkg::OP_STATUS, 1'b0, 48'd0, 8'd0, 8'h83, 16'd0));
		add_step(pio(ata_seq_pkg::OP_STATUS, 1'b0, 48'd0, 8'd0, 8'h00, 16'd0));
		add_step(pio(ata_seq_pkg::OP_STATUS, 1'b0, 48'd0, 8'd0, 8'h09, 16'd0));
		add_step(pio(ata_seq_pkg::OP_DATA, 1'b0, 48'd0, 8'd0, 8'd0, 16'hFFFF));
		add_step(pio(ata_seq_pkg::OP_DATA, 1'b0, 48'd0, 8'd0, 8'd0, 16'h0000));
		// error register with no bit set, then device fault
		add_step(pio(ata_seq_pkg::OP_START, 1'b0, 48'd5, 8'd1, 8'd0, 16'd0));
		add_step(pio(ata_seq_pkg::OP_STATUS, 1'b0, 48'd0, 8'd0, 8'h01, 16'd0));
		add_fail(pio(ata_seq_pkg::OP_ERROR, 1'b0, 48'd0, 8'd0, 8'h00, 16'd0),
			ata_seq_pkg::ERR_NO_BIT);
		add_step(pio(ata_seq_pkg::OP_START, 1'b0, 48'd6, 8'd2, 8'd0, 16'd0));
		add_fail(pio(ata_seq_pkg::OP_STATUS, 1'b0, 48'd0, 8'd0, 8'h02, 16'd0),
			ata_seq_pkg::ERR_FAULT);
		// write sector: err and df are not looked at
		add_step(pio(ata_seq_pkg::OP_START, 1'b1, 48'd7, 8'd1, 8'd0, 16'd0));
		add_step(pio(ata_seq_pkg::OP_STATUS, 1'b0, 48'd0, 8'd0, 8'h03, 16'd0));
		add_step(pio(ata_seq_pkg::OP_DATA, 1'b0, 48'd0, 8'd0, 8'd0, 16'h1234));
		add_step(pio(ata_seq_pkg::OP_DATA, 1'b0, 48'd0, 8'd0, 8'd0, 16'hA5A5));
		add_step(pio(ata_seq_pkg::OP_STATUS, 1'b0, 48'd0, 8'd0, 8'h00, 16'd0));
		// sectors with no data words
		add_cfg(ata_seq_pkg::CFG_WORDS, 48'd0);
		add_step(pio(ata_seq_pkg::OP_START, 1'b0, 48'd8, 8'd2, 8'd0, 16'd0));
		add_step(pio(ata_seq_pkg::OP_STATUS, 1'b0, 48'd0, 8'd0, 8'h08, 16'd0));
		add_step(pio(ata_seq_pkg::OP_STATUS, 1'b0, 48'd0, 8'd0, 8'h08, 16'd0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				write_reg(plan[i].cfg_idx, plan[i].cfg_val);
			end else
				offer(plan[i].item, plan[i].typed, plan[i].code, taken);
		end

		// random phases under different register settings
		for (int ph = 0; ph < 3; ph++) begin
			settle();
			case (ph)
				0: begin
					write_reg(ata_seq_pkg::CFG_CAPACITY, 48'h0000_1000_0020);
					write_reg(ata_seq_pkg::CFG_WORDS, 48'd1);
					write_reg(ata_seq_pkg::CFG_SLAVE, 48'd0);
				end
				1: begin
					write_reg(ata_seq_pkg::CFG_CAPACITY, MAX48);
					write_reg(ata_seq_pkg::CFG_WORDS, 48'd3);
					write_reg(ata_seq_pkg::CFG_SLAVE, 48'd1);
					write_reg(CFG_SPARE, 48'({$urandom, $urandom}));
				end
				default: begin
					write_reg(ata_seq_pkg::CFG_CAPACITY, 48'($urandom_range(2000, 100)));
					write_reg(ata_seq_pkg::CFG_WORDS, 48'($urandom_range(4, 1)));
					write_reg(ata_seq_pkg::CFG_SLAVE, 48'($urandom_range(1)));
				end
			endcase
			k = 0;
			while (k < 50) begin
				if (ph == 0 && k == 20)
					steady <= 1'b1;
				if (ph == 0 && k == 45)
					steady <= 1'b0;
				if (ph == 1 && k == 10)
					hold_go = 1'b1;
				it = pick_item(1'b0);
				offer(it, 1'b0, ata_seq_pkg::ERR_NONE, taken);
				if (taken)
					k++;
			end
		end

		settle();

		$display("covered %0d input beats (%0d acted on) and %0d result beats in %0d cycles",
			items_sent, items_taken, beats_seen, cycle_count);
		if (fail_count == 0)
			$display("ata_pio_lba28_command_sequencer_test OK");
		else
			$display("ata_pio_lba28_command_sequencer_test NOT OK");
		$finish;
	end

endmodule
